// ===== sv/signed_barrett_modular_reducer_defines.svh =====
// Assertion macros for the signed Barrett modular reducer.
`ifndef SIGNED_BARRETT_MODULAR_REDUCER_DEFINES_SVH
`define SIGNED_BARRETT_MODULAR_REDUCER_DEFINES_SVH

`ifndef ASSERT_OFF

// Checked only while out of reset.
`define SBMR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define SBMR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`else

`define SBMR_ASSERT(lbl, prop, msg)
`define SBMR_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

// ===== sv/sbmr_pkg.sv =====
// Shared types and constants for the signed Barrett modular reducer.
`default_nettype none

package sbmr_pkg;

  localparam int DATA_W    = 32;  // operand and residue width
  localparam int MOD_W     = 23;  // modulus register width
  localparam int DIV_W     = 24;  // divisor width (2q needs one more bit)
  localparam int REC_W     = 33;  // widest reciprocal
  localparam int REC2_W    = 32;  // reciprocal of 2q
  localparam int REC_LO_W  = 17;  // low slice of the reciprocal product split
  localparam int CFG_IDX_W = 2;

  localparam int SHIFT_BITS_DEF = 46;

  // operation codes
  localparam logic [2:0] OP_TRUNC_Q = 3'd0;
  localparam logic [2:0] OP_ADD_Q   = 3'd1;
  localparam logic [2:0] OP_MOD_Q   = 3'd2;
  localparam logic [2:0] OP_ADD_2Q  = 3'd3;
  localparam logic [2:0] OP_MOD_2Q  = 3'd4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MODULUS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RECIP_Q  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RECIP_2Q = 2'd2;

  localparam logic [MOD_W-1:0]  MODULUS_RST  = 23'd15361;
  localparam logic [REC_W-1:0]  RECIP_Q_RST  = 33'd4581000206;
  localparam logic [REC2_W-1:0] RECIP_2Q_RST = 32'd2290500103;

  // request data that rides along the pipeline
  typedef struct packed {
    logic [2:0]        op;
    logic [DATA_W-1:0] a;    // operand as given
    logic [DATA_W-1:0] au;   // magnitude
    logic              neg;  // operand sign
    logic [DIV_W-1:0]  d;    // divisor / addend for this request
  } side_t;

endpackage

`default_nettype wire

// ===== sv/sbmr_recip_mul.sv =====
// Two-stage reciprocal multiply: magnitude times reciprocal, shifted down.
`default_nettype none

module sbmr_recip_mul #(
  parameter int SHIFT_BITS = sbmr_pkg::SHIFT_BITS_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         valid_i,
  input  wire logic [sbmr_pkg::REC_W-1:0]   rec_i,
  input  wire sbmr_pkg::side_t              side_i,
  output logic                              valid_o,
  output logic [sbmr_pkg::DATA_W-1:0]       qh_o,
  output sbmr_pkg::side_t                   side_o
);

  localparam int REC_HI_W = sbmr_pkg::REC_W - sbmr_pkg::REC_LO_W;
  localparam int PLO_W    = sbmr_pkg::DATA_W + sbmr_pkg::REC_LO_W;
  localparam int PHI_W    = sbmr_pkg::DATA_W + REC_HI_W;
  localparam int SUM_W    = SHIFT_BITS + sbmr_pkg::DATA_W;

  logic             pv_q;
  logic [PLO_W-1:0] plo_d, plo_q;
  logic [PHI_W-1:0] phi_d, phi_q;
  sbmr_pkg::side_t  pside_q;
  logic [SUM_W-1:0] sum;
  logic             qv_q;
  logic [sbmr_pkg::DATA_W-1:0] qh_q;
  sbmr_pkg::side_t  qside_q;

  // partial products
  assign plo_d = PLO_W'(side_i.au) * PLO_W'(rec_i[sbmr_pkg::REC_LO_W-1:0]);
  assign phi_d = PHI_W'(side_i.au) * PHI_W'(rec_i[sbmr_pkg::REC_W-1:sbmr_pkg::REC_LO_W]);

  // recombine; the top DATA_W bits are the product shifted by SHIFT_BITS
  assign sum = SUM_W'(plo_q) + (SUM_W'(phi_q) << sbmr_pkg::REC_LO_W);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= 1'b0;
      qv_q <= 1'b0;
    end else begin
      pv_q <= valid_i;
      qv_q <= pv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      plo_q   <= plo_d;
      phi_q   <= phi_d;
      pside_q <= side_i;
    end
    if (pv_q) begin
      qh_q    <= sum[SUM_W-1 -: sbmr_pkg::DATA_W];
      qside_q <= pside_q;
    end
  end

  assign valid_o = qv_q;
  assign qh_o    = qh_q;
  assign side_o  = qside_q;

endmodule

`default_nettype wire

// ===== sv/sbmr_correct.sv =====
// Quotient times divisor, subtract, one correction and sign restore.
`default_nettype none

module sbmr_correct (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         valid_i,
  input  wire logic [sbmr_pkg::DATA_W-1:0]  qh_i,
  input  wire sbmr_pkg::side_t              side_i,
  output logic                              valid_o,
  output logic [sbmr_pkg::DATA_W-1:0]       rem_o,
  output sbmr_pkg::side_t                   side_o
);

  localparam int DW = sbmr_pkg::DATA_W;

  logic          mv_q;
  logic [DW-1:0] qd_d, qd_q;
  sbmr_pkg::side_t mside_q;
  logic [DW-1:0] d32, r, r2, rs;
  logic          ge;
  logic          rv_q;
  logic [DW-1:0] rem_q;
  sbmr_pkg::side_t rside_q;

  // only the low word of qh * d matters
  assign qd_d = DW'(qh_i * DW'(side_i.d));

  assign d32 = DW'(mside_q.d);

  assign r  = mside_q.au - qd_q;
  assign ge = (r >= d32);
  assign r2 = ge ? (r - d32) : r;
  assign rs = mside_q.neg ? (DW'(0) - r2) : r2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mv_q <= 1'b0;
      rv_q <= 1'b0;
    end else begin
      mv_q <= valid_i;
      rv_q <= mv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      qd_q    <= qd_d;
      mside_q <= side_i;
    end
    if (mv_q) begin
      rem_q   <= rs;
      rside_q <= mside_q;
    end
  end

  assign valid_o = rv_q;
  assign rem_o   = rem_q;
  assign side_o  = rside_q;

endmodule

`default_nettype wire

// ===== sv/signed_barrett_modular_reducer.sv =====
// Top level of the signed Barrett modular reducer pipeline.
//
//  channel   ports                                      direction  handshake
//  ------------------------------------------------------------------------------
//  request   start_i, busy_o, req_type_i, operand_i     in         start_i && !busy_o
//  result    done_o, residue_o                          out        done_o, one cycle
//  config    cfg_we_i, cfg_idx_i, cfg_wdata_i           in         cfg_we_i, no wait
//
//  One request per cycle, every cycle; results leave in the order of their requests.
//  The six-stage pipeline splits the 32x33 reciprocal product over two multipliers
//  and a recombining add, then does the 32x24 back-multiply.
//  busy_o is always low: nothing in the pipeline ever holds, and results cannot stall.
//  Reset clears the stage valid bits and loads the reset modulus and reciprocals.
//  Registers are to be written only while no request is in flight.
`default_nettype none

module signed_barrett_modular_reducer #(
  parameter int SHIFT_BITS = sbmr_pkg::SHIFT_BITS_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // request
  input  wire logic                             start_i,
  output logic                                  busy_o,
  input  wire logic [2:0]                       req_type_i,
  input  wire logic signed [sbmr_pkg::DATA_W-1:0] operand_i,
  // result
  output logic                                  done_o,
  output logic signed [sbmr_pkg::DATA_W-1:0]    residue_o,
  // configuration
  input  wire logic                             cfg_we_i,
  input  wire logic [sbmr_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [sbmr_pkg::REC_W-1:0]       cfg_wdata_i
);

`include "signed_barrett_modular_reducer_defines.svh"

  localparam int DW = sbmr_pkg::DATA_W;

  logic accept;

  // configuration registers
  logic [sbmr_pkg::MOD_W-1:0]  modulus_q;
  logic [sbmr_pkg::REC_W-1:0]  recip_q_q;
  logic [sbmr_pkg::REC2_W-1:0] recip_2q_q;

  // stage 1: magnitude, divisor and reciprocal selection
  sbmr_pkg::side_t            side_d, s1_side_q;
  logic [sbmr_pkg::REC_W-1:0] rec_d, s1_rec_q;
  logic                       s1_valid_q;
  logic [DW-1:0]              a_u;
  logic [sbmr_pkg::DIV_W-1:0] q24, dq24;

  // stages 2-3
  logic                       m_valid;
  logic [DW-1:0]              m_qh;
  sbmr_pkg::side_t            m_side;

  // stages 4-5
  logic                       c_valid;
  logic [DW-1:0]              c_rem;
  sbmr_pkg::side_t            c_side;

  // stage 6: output register
  logic [DW-1:0]              out_d32;
  logic [DW-1:0]              res_d, res_q;
  logic                       done_q;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  // register writes; index 3 is not a register and is dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q  <= sbmr_pkg::MODULUS_RST;
      recip_q_q  <= sbmr_pkg::RECIP_Q_RST;
      recip_2q_q <= sbmr_pkg::RECIP_2Q_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        sbmr_pkg::CFG_MODULUS:  modulus_q  <= cfg_wdata_i[sbmr_pkg::MOD_W-1:0];
        sbmr_pkg::CFG_RECIP_Q:  recip_q_q  <= cfg_wdata_i;
        sbmr_pkg::CFG_RECIP_2Q: recip_2q_q <= cfg_wdata_i[sbmr_pkg::REC2_W-1:0];
        default: ;
      endcase
    end
  end

  assign a_u  = DW'(operand_i);
  assign q24  = sbmr_pkg::DIV_W'(modulus_q);
  assign dq24 = {modulus_q, 1'b0};

  always_comb begin
    side_d.op  = req_type_i;
    side_d.a   = a_u;
    side_d.neg = a_u[DW-1];
    // most negative value gives 2^31 as an unsigned magnitude
    side_d.au  = a_u[DW-1] ? (DW'(0) - a_u) : a_u;
    case (req_type_i) inside
      sbmr_pkg::OP_ADD_2Q, sbmr_pkg::OP_MOD_2Q: side_d.d = dq24;
      default:                                  side_d.d = q24;
    endcase
    rec_d = (req_type_i == sbmr_pkg::OP_MOD_2Q) ? sbmr_pkg::REC_W'(recip_2q_q) : recip_q_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_side_q <= side_d;
      s1_rec_q  <= rec_d;
    end
  end

  sbmr_recip_mul #(
    .SHIFT_BITS (SHIFT_BITS)
  ) u_recip_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s1_valid_q),
    .rec_i   (s1_rec_q),
    .side_i  (s1_side_q),
    .valid_o (m_valid),
    .qh_o    (m_qh),
    .side_o  (m_side)
  );

  sbmr_correct u_correct (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (m_valid),
    .qh_i    (m_qh),
    .side_i  (m_side),
    .valid_o (c_valid),
    .rem_o   (c_rem),
    .side_o  (c_side)
  );

  // final pick: truncated remainder, add-if-negative on operand or on remainder
  assign out_d32 = DW'(c_side.d);

  always_comb begin
    case (c_side.op) inside
      sbmr_pkg::OP_TRUNC_Q:
        res_d = c_rem;
      sbmr_pkg::OP_ADD_Q, sbmr_pkg::OP_ADD_2Q:
        res_d = c_side.a[DW-1] ? (c_side.a + out_d32) : c_side.a;
      sbmr_pkg::OP_MOD_Q, sbmr_pkg::OP_MOD_2Q:
        res_d = c_rem[DW-1] ? (c_rem + out_d32) : c_rem;
      default:
        res_d = c_side.a;  // unused codes pass the operand through
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= c_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (c_valid) begin
      res_q <= res_d;
    end
  end

  assign done_o    = done_q;
  assign residue_o = $signed(res_q);

  // every accepted request gets a result and every result had a request, both directions
  `SBMR_ASSERT(a_latency, accept |-> ##6 done_o, "request did not complete in six cycles")
  `SBMR_ASSERT(a_no_phantom, done_o |-> $past(accept, 6), "result without a request")
  // result word only moves together with the strobe
  `SBMR_ASSERT(a_hold, !done_o |-> $stable(residue_o), "residue changed without a result")
  // unused codes: operand must come back aligned with its own request
  `SBMR_ASSERT(a_pass, done_o && $past(req_type_i > sbmr_pkg::OP_MOD_2Q, 6) |-> residue_o == $past(operand_i, 6), "pass-through operand misaligned")
  `SBMR_ASSERT_ALWAYS(a_rst_quiet, !rst_ni |-> !done_o, "result strobe during reset")

endmodule

`default_nettype wire
